// File: rtl/sensor_frame_crc8_serializer_assert.svh
// ----------------------------------------------------------------------------
// Sensor frame serializer assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC8_SERIALIZER_ASSERT_SVH
`define SENSOR_FRAME_CRC8_SERIALIZER_ASSERT_SVH

`ifndef SYNTH
// Implication checked on every clock edge outside reset
`define SFCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle requires a consequence in the next
`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame serializer package
// Shared types, register indexes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package sfcs_pkg;

	// Frame layout
	localparam int DATA_BYTES = 10;
	localparam int DATA_CNT_W = $clog2(DATA_BYTES);
	localparam logic [7:0] CRC_POLY = 8'h07;

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE  = CFG_IDX_W'(1);
	localparam logic [7:0] START_BYTE_RST = 8'h02;
	localparam logic [7:0] STOP_BYTE_RST  = 8'h03;

	// Front queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One sample set, first transmitted field in the top bits
	typedef struct packed {
		logic [15:0] volume;
		logic [15:0] temperature_a;
		logic [15:0] temperature_b;
		logic [15:0] humidity_a;
		logic [15:0] humidity_b;
	} sample_t;

	// Head of the front queue as seen by the back end
	typedef struct packed {
		logic    valid;
		sample_t data;
	} queue_head_t;

	// Serializer phases
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_DATA,
		ST_CRC,
		ST_TAIL
	} ser_state_t;

	// CRC-8/SMBUS over one byte, MSB first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/sfcs_front.sv
// ----------------------------------------------------------------------------
// Sensor frame serializer front end
// Takes sample sets on the command port and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sfcs_front import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sample_t     sample,
	output queue_head_t head,
	input  logic        pop
);

	sample_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop_ok;

	// Queue status
	assign busy   = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push   = start && !busy;
	assign pop_ok = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.data  = entry_q[rd_ptr_q];

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= sample;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/sfcs_back.sv
// ----------------------------------------------------------------------------
// Sensor frame serializer back end
// Sends one 13-byte frame per sample set, one beat per cycle, with CRC-8.
// ----------------------------------------------------------------------------
module sfcs_back import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	input  logic [7:0]  start_byte,
	input  logic [7:0]  stop_byte,
	output logic        byte_strobe,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	ser_state_t             state_q, state_d;
	logic [DATA_CNT_W-1:0]  cnt_q, cnt_d;
	logic [$bits(sample_t)-1:0] shift_q, shift_d;
	logic [7:0]             crc_q, crc_d;
	logic                   strobe_d, last_d;
	logic [7:0]             byte_d;
	logic                   strobe_q, last_q;
	logic [7:0]             byte_q;

	// Next state, datapath updates and the beat to send
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		crc_d    = crc_q;
		pop      = 1'b0;
		strobe_d = 1'b0;
		last_d   = 1'b0;
		byte_d   = shift_q[$bits(sample_t)-1 -: 8];
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					shift_d = head.data;
					crc_d   = '0;
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				strobe_d = 1'b1;
				byte_d   = start_byte;
				cnt_d    = '0;
				state_d  = ST_DATA;
			end
			ST_DATA: begin
				strobe_d = 1'b1;
				crc_d    = crc8_update(crc_q, shift_q[$bits(sample_t)-1 -: 8]);
				shift_d  = {shift_q[$bits(sample_t)-9:0], 8'h00};
				cnt_d    = cnt_q + DATA_CNT_W'(1);
				if (cnt_q == DATA_CNT_W'(DATA_BYTES - 1)) begin
					state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				strobe_d = 1'b1;
				byte_d   = crc_q;
				state_d  = ST_TAIL;
			end
			ST_TAIL: begin
				strobe_d = 1'b1;
				last_d   = 1'b1;
				byte_d   = stop_byte;
				// next frame follows without a gap
				if (head.valid) begin
					pop     = 1'b1;
					shift_d = head.data;
					crc_d   = '0;
					state_d = ST_HEAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
			last_q   <= last_d;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		crc_q   <= crc_d;
		byte_q  <= byte_d;
	end

	assign byte_strobe = strobe_q;
	assign frame_byte  = byte_q;
	assign last_byte   = last_q;

endmodule

// File: rtl/sensor_frame_crc8_serializer.sv
// ----------------------------------------------------------------------------
// Sensor frame serializer with CRC-8/SMBUS
// Five 16-bit readings in, one 13-byte framed packet out per sample set.
// ----------------------------------------------------------------------------
// A sample set is taken when start is high and busy is low. Each set becomes a
// frame of 13 beats on frame_byte, one per cycle, each marked by byte_strobe:
// the start byte, the five readings high byte first, a CRC-8/SMBUS over the
// ten data bytes, and the stop byte with last_byte high. An accepted set is
// popped from the front queue into the serializer, whose beats are registered.
// The byte serializer sets the rate; consecutive frames follow with no gap.
// Two sets can wait in the front queue, so busy rises only when both slots are
// full. The receiver cannot stall: every beat must be taken in its cycle.
// start_byte (index 0, reset 0x02) and stop_byte (index 1, reset 0x03) are
// written through the cfg port, which is always ready; other indexes are
// ignored. Write them only while no frame is pending.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc8_serializer_assert.svh"

module sensor_frame_crc8_serializer import sfcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [15:0]          volume,
	input  logic [15:0]          temperature_a,
	input  logic [15:0]          temperature_b,
	input  logic [15:0]          humidity_a,
	input  logic [15:0]          humidity_b,
	output logic                 byte_strobe,
	output logic [7:0]           frame_byte,
	output logic                 last_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]  start_byte_q;
	logic [7:0]  stop_byte_q;
	sample_t     sample;
	queue_head_t head;
	logic        pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			stop_byte_q  <= STOP_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_data;
				REG_STOP_BYTE:  stop_byte_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Input beat
	assign sample.volume        = volume;
	assign sample.temperature_a = temperature_a;
	assign sample.temperature_b = temperature_b;
	assign sample.humidity_a    = humidity_a;
	assign sample.humidity_b    = humidity_b;

	sfcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.head   (head),
		.pop    (pop)
	);

	sfcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.start_byte  (start_byte_q),
		.stop_byte   (stop_byte_q),
		.byte_strobe (byte_strobe),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	// Checks
	`SFCS_ASSERT(a_last_has_strobe, clk, arst_n, last_byte |-> byte_strobe, "last_byte without strobe")
	`SFCS_ASSERT(a_frame_contiguous, clk, arst_n, (byte_strobe && last_byte) |-> $past(byte_strobe, 12), "frame beats not contiguous")
	`SFCS_ASSERT(a_stop_value, clk, arst_n, last_byte |-> (frame_byte == stop_byte_q), "last beat is not the stop byte")
	`SFCS_ASSERT_NEXT(a_pop_starts_frame, clk, arst_n, pop, byte_strobe == last_byte, "frame start misplaced")

endmodule
